### rtl/xoshiro256pp_prng_with_splitmix_seed_unit_assert.svh
// Assertion macros shared by the generator RTL.
`ifndef XOSHIRO256PP_PRNG_WITH_SPLITMIX_SEED_UNIT_ASSERT_SVH
`define XOSHIRO256PP_PRNG_WITH_SPLITMIX_SEED_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define XSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define XSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/xsp_pkg.sv
package xsp_pkg;

  typedef logic [63:0] word_t;

  // Operation codes on func
  localparam logic [1:0] FUNC_NEXT   = 2'd0;
  localparam logic [1:0] FUNC_SPARSE = 2'd1;
  localparam logic [1:0] FUNC_SEED   = 2'd2;

  // SplitMix64 constants
  localparam word_t GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam word_t MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam word_t MIX_MUL_B    = 64'h94d049bb133111eb;

  // Request to / response from the shared multiplier
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

endpackage

### rtl/xsp_mul.sv
`include "xoshiro256pp_prng_with_splitmix_seed_unit_assert.svh"

// Low 64 bits of a 64x64 product, from one 32x32 multiplier over three passes.
module xsp_mul (
  input  logic             clk,
  input  logic             rst,
  input  xsp_pkg::mul_req_t req,
  output xsp_pkg::mul_rsp_t rsp
);
  import xsp_pkg::*;

  logic        run;
  logic [1:0]  ph;
  logic        done;
  word_t       op_a;
  word_t       op_b;
  word_t       preg;
  word_t       acc;
  logic [31:0] mx;
  logic [31:0] my;
  word_t       mprod;

  // lo*lo, hi*lo, lo*hi; hi*hi never reaches the low word
  always_comb begin
    case (ph)
      2'd0: begin
        mx = op_a[31:0];
        my = op_b[31:0];
      end
      2'd1: begin
        mx = op_a[63:32];
        my = op_b[31:0];
      end
      default: begin
        mx = op_a[31:0];
        my = op_b[63:32];
      end
    endcase
  end

  // upper halves are zero, so this is a 32x32 array with a full 64-bit product
  assign mprod = {32'h0, mx} * {32'h0, my};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      ph   <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= run && (ph == 2'd3);
      if (req.start) begin
        run <= 1'b1;
        ph  <= 2'd0;
      end else if (run) begin
        ph <= ph + 2'd1;
        if (ph == 2'd3) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_a <= req.a;
      op_b <= req.b;
    end
    if (run) begin
      preg <= mprod;
      case (ph)
        2'd1: begin
          acc <= preg;
        end
        2'd2, 2'd3: begin
          acc <= acc + {preg[31:0], 32'h0};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

  `XSP_ASSERT_NOW(a_start_idle, req.start, !run, "multiply started while busy")
  `XSP_ASSERT_NOW(a_done_idle, done, !run, "done raised while still running")
  `XSP_ASSERT_NEXT(a_done_after_last, run && (ph == 2'd3), done, "done missing after last pass")

endmodule

### rtl/xoshiro256pp_prng_with_splitmix_seed_unit.sv
// Next runs the sum and step states once and sparse repeats them, then done loads the output.
// A new request is stalled until the sequencer is idle again; a word waiting
// on the output does not block accept, only the final load into the output register.
// Reseed gives no word: each generator word takes two SplitMix multiplies on the shared
// 32x32 multiplier.
// Reset (rst, synchronous): generator words go to zero, sequencer idle, no word pending.
`include "xoshiro256pp_prng_with_splitmix_seed_unit_assert.svh"

module xoshiro256pp_prng_with_splitmix_seed_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          func,
  input  xsp_pkg::word_t      seed_value,
  output logic                out_valid,
  input  logic                out_stall,
  output xsp_pkg::word_t      random_value
);
  import xsp_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_SUM  = 3'd1;  // w0 + w3 into sum
  localparam logic [2:0] S_STEP = 3'd2;  // output mix and state advance
  localparam logic [2:0] S_DONE = 3'd3;  // load output register
  localparam logic [2:0] S_SADD = 3'd4;  // SplitMix counter += gamma
  localparam logic [2:0] S_MXA  = 3'd5;  // first multiply start
  localparam logic [2:0] S_MWA  = 3'd6;  // wait first, start second
  localparam logic [2:0] S_MWB  = 3'd7;  // wait second, store word

  logic [2:0] st;
  logic [1:0] left;     // generator steps still to run
  logic [1:0] widx;     // generator word being seeded
  word_t      gw [4];   // generator state
  word_t      sum;
  word_t      and_acc;  // running AND for sparse
  word_t      ctr;      // SplitMix counter
  word_t      step_out;
  word_t      n0, n1, n2, n3;
  word_t      x3;
  word_t      z;
  logic       accept;
  logic       gen_req;  // accepted next or sparse
  logic       out_free;
  mul_req_t   mreq;
  mul_rsp_t   mrsp;

  assign in_stall = (st != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign gen_req  = accept && ((func == FUNC_NEXT) || (func == FUNC_SPARSE));
  // output register can take a word this cycle
  assign out_free = !out_valid || !out_stall;

  // xoshiro256++ output and next state
  assign step_out = {sum[40:0], sum[63:41]} + gw[0];
  assign n2 = gw[2] ^ gw[0] ^ {gw[1][46:0], 17'h0};
  assign x3 = gw[3] ^ gw[1];
  assign n1 = gw[1] ^ gw[2] ^ gw[0];
  assign n0 = gw[0] ^ x3;
  assign n3 = {x3[18:0], x3[63:19]};

  // SplitMix final xor-shift on the second product
  assign z = mrsp.prod ^ {31'h0, mrsp.prod[63:31]};

  // One multiplier serves both SplitMix multiplies
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = ctr ^ {30'h0, ctr[63:30]};
    mreq.b     = MIX_MUL_A;
    case (st)
      S_MXA: begin
        mreq.start = 1'b1;
      end
      S_MWA: begin
        mreq.start = mrsp.done;
        mreq.a     = mrsp.prod ^ {27'h0, mrsp.prod[63:27]};
        mreq.b     = MIX_MUL_B;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  xsp_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Sequencer and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      left  <= 2'd0;
      widx  <= 2'd0;
      gw[0] <= '0;
      gw[1] <= '0;
      gw[2] <= '0;
      gw[3] <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (accept) begin
            case (func)
              FUNC_NEXT: begin
                left <= 2'd1;
                st   <= S_SUM;
              end
              FUNC_SPARSE: begin
                left <= 2'd3;
                st   <= S_SUM;
              end
              FUNC_SEED: begin
                widx <= 2'd0;
                st   <= S_SADD;
              end
              default: begin
                st <= S_IDLE;  // unused code: dropped
              end
            endcase
          end
        end
        S_SUM: begin
          st <= S_STEP;
        end
        S_STEP: begin
          gw[0] <= n0;
          gw[1] <= n1;
          gw[2] <= n2;
          gw[3] <= n3;
          left  <= left - 2'd1;
          st    <= (left == 2'd1) ? S_DONE : S_SUM;
        end
        S_DONE: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        S_SADD: begin
          st <= S_MXA;
        end
        S_MXA: begin
          st <= S_MWA;
        end
        S_MWA: begin
          if (mrsp.done) begin
            st <= S_MWB;
          end
        end
        S_MWB: begin
          if (mrsp.done) begin
            gw[widx] <= z;
            widx     <= widx + 2'd1;
            st       <= (widx == 2'd3) ? S_IDLE : S_SADD;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ctr     <= seed_value;
      and_acc <= '1;
    end
    if (st == S_SUM) begin
      sum <= gw[0] + gw[3];
    end
    if (st == S_STEP) begin
      and_acc <= and_acc & step_out;
    end
    if (st == S_SADD) begin
      ctr <= ctr + GOLDEN_GAMMA;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((st == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st == S_DONE) && out_free) begin
      random_value <= and_acc;
    end
  end

  `XSP_ASSERT_NOW(a_out_from_done, $rose(out_valid), $past(st) == S_DONE, "word not from done")
  `XSP_ASSERT_NEXT(a_gen_to_sum, gen_req, st == S_SUM, "step not started")
  `XSP_ASSERT_NOW(a_step_count, st == S_STEP, left != 2'd0, "step with no count left")
  `XSP_ASSERT_NOW(a_mul_waited, mrsp.done, (st == S_MWA) || (st == S_MWB), "stray product")

endmodule
